// ===== hdl/divider_128_signed_unsigned_core_defines.svh =====
// Assertion macros for the divider core checker.
// Include from any file that asserts on the aclk / aresetn domain.
`ifndef DIVIDER_128_SIGNED_UNSIGNED_CORE_DEFINES_SVH
`define DIVIDER_128_SIGNED_UNSIGNED_CORE_DEFINES_SVH

// check while out of reset
`define DIV128_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check through reset as well
`define DIV128_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/div128_pkg.sv =====
// Shared constants and types for the pipelined 128-bit divider.
// No dependencies; imported by every module of the core.
package div128_pkg;

    localparam int OPERAND_WIDTH_DEF = 128;
    localparam int HALF_W            = 64;
    localparam int FULL_W            = 2 * HALF_W;
    localparam int DATA_W            = 4 * HALF_W;

    localparam logic OPC_UNSIGNED = 1'b0;
    localparam logic OPC_SIGNED   = 1'b1;

    typedef struct packed {
        logic neg_q;
        logic neg_r;
        logic dbz;
    } ctl_t;

endpackage

// ===== hdl/div128_prep.sv =====
// Input stage: masks operands to the operand width, takes magnitudes in
// signed mode, flags a zero divisor. Depends on div128_pkg.
module div128_prep
    import div128_pkg::*;
#(
    parameter int WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  logic             in_opcode,
    input  logic [FULL_W-1:0] in_dividend,
    input  logic [FULL_W-1:0] in_divisor,
    output logic             out_valid,
    output ctl_t             out_ctl,
    output logic [WIDTH-1:0] out_nq,
    output logic [WIDTH-1:0] out_dsr
);

    logic [WIDTH-1:0] n;
    logic [WIDTH-1:0] d;
    logic             n_neg;
    logic             d_neg;

    logic             valid_reg;
    ctl_t             ctl_reg;
    ctl_t             ctl_next;
    logic [WIDTH-1:0] nq_reg;
    logic [WIDTH-1:0] nq_next;
    logic [WIDTH-1:0] dsr_reg;
    logic [WIDTH-1:0] dsr_next;

    always_comb begin
        n        = in_dividend[WIDTH-1:0];
        d        = in_divisor[WIDTH-1:0];
        n_neg    = (in_opcode == OPC_SIGNED) && n[WIDTH-1];
        d_neg    = (in_opcode == OPC_SIGNED) && d[WIDTH-1];
        nq_next  = n_neg ? ('0 - n) : n;
        dsr_next = d_neg ? ('0 - d) : d;
        ctl_next.neg_q = n_neg ^ d_neg;
        ctl_next.neg_r = n_neg;
        ctl_next.dbz   = (d == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg <= ctl_next;
            nq_reg  <= nq_next;
            dsr_reg <= dsr_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_nq    = nq_reg;
    assign out_dsr   = dsr_reg;

endmodule

// ===== hdl/div128_cell.sv =====
// One restoring division step: shifts the next dividend bit into the partial
// remainder, subtracts the divisor when it fits. Depends on div128_pkg.
module div128_cell
    import div128_pkg::*;
#(
    parameter int WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  ctl_t             in_ctl,
    input  logic [WIDTH-1:0] in_rem,
    input  logic [WIDTH-1:0] in_nq,
    input  logic [WIDTH-1:0] in_dsr,
    output logic             out_valid,
    output ctl_t             out_ctl,
    output logic [WIDTH-1:0] out_rem,
    output logic [WIDTH-1:0] out_nq,
    output logic [WIDTH-1:0] out_dsr
);

    logic [WIDTH:0]   rs;
    logic [WIDTH+1:0] diff;
    logic             fits;

    logic             valid_reg;
    ctl_t             ctl_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] nq_reg;
    logic [WIDTH-1:0] nq_next;
    logic [WIDTH-1:0] dsr_reg;

    always_comb begin
        rs       = {in_rem, in_nq[WIDTH-1]};
        diff     = {1'b0, rs} - {2'b00, in_dsr};
        fits     = !diff[WIDTH+1];
        rem_next = fits ? diff[WIDTH-1:0] : rs[WIDTH-1:0];
        nq_next  = {in_nq[WIDTH-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg <= in_ctl;
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            dsr_reg <= in_dsr;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_dsr   = dsr_reg;

endmodule

// ===== hdl/div128_fin.sv =====
// Output stage: restores signs, forces zeros on a zero divisor and holds the
// result beat for the master side. Depends on div128_pkg.
module div128_fin
    import div128_pkg::*;
#(
    parameter int WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  ctl_t              in_ctl,
    input  logic [WIDTH-1:0]  in_rem,
    input  logic [WIDTH-1:0]  in_quo,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_data,
    output logic              out_dbz
);

    logic [WIDTH-1:0]  q;
    logic [WIDTH-1:0]  r;
    logic [FULL_W-1:0] q_ext;
    logic [FULL_W-1:0] r_ext;

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              dbz_reg;

    always_comb begin
        q = in_ctl.neg_q ? ('0 - in_quo) : in_quo;
        r = in_ctl.neg_r ? ('0 - in_rem) : in_rem;
        q_ext = '0;
        r_ext = '0;
        if (!in_ctl.dbz) begin
            q_ext[WIDTH-1:0] = q;
            r_ext[WIDTH-1:0] = r;
        end
        data_next = {r_ext[HALF_W-1:0], r_ext[FULL_W-1:HALF_W],
                     q_ext[HALF_W-1:0], q_ext[FULL_W-1:HALF_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
            dbz_reg  <= in_ctl.dbz;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_dbz   = dbz_reg;

endmodule

// ===== hdl/divider_128_signed_unsigned_core.sv =====
// Pipelined signed/unsigned divider: a row of OPERAND_WIDTH division cells.
// Result path from input beat to result beat: input stage, one cell per
// quotient bit, output register.
// Throughput: one beat per cycle; a stalled result freezes the whole row.
// Reset (aresetn low, synchronous) clears only the stage valid bits.
module divider_128_signed_unsigned_core
    import div128_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // dividend_hi, dividend_lo, divisor_hi, divisor_lo (64 bits each)
    input  logic [DATA_W-1:0] s_tdata,
    // opcode
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // quotient_hi, quotient_lo, remainder_hi, remainder_lo (64 bits each)
    output logic [DATA_W-1:0] m_tdata,
    // divide_by_zero
    output logic              m_tuser
);

    logic                     adv;
    logic                     vld   [OPERAND_WIDTH+1];
    ctl_t                     ctl   [OPERAND_WIDTH+1];
    logic [OPERAND_WIDTH-1:0] rem   [OPERAND_WIDTH+1];
    logic [OPERAND_WIDTH-1:0] nq    [OPERAND_WIDTH+1];
    logic [OPERAND_WIDTH-1:0] dsr   [OPERAND_WIDTH+1];
    logic [FULL_W-1:0]        dividend;
    logic [FULL_W-1:0]        divisor;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign dividend = {s_tdata[HALF_W-1:0], s_tdata[FULL_W-1:HALF_W]};
    assign divisor  = {s_tdata[FULL_W+HALF_W-1:FULL_W], s_tdata[DATA_W-1:FULL_W+HALF_W]};
    assign rem[0]   = '0;

    div128_prep #(
        .WIDTH(OPERAND_WIDTH)
    ) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_opcode  (s_tuser),
        .in_dividend(dividend),
        .in_divisor (divisor),
        .out_valid  (vld[0]),
        .out_ctl    (ctl[0]),
        .out_nq     (nq[0]),
        .out_dsr    (dsr[0])
    );

    for (genvar i = 0; i < OPERAND_WIDTH; i++) begin : g_cell
        div128_cell #(
            .WIDTH(OPERAND_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_valid (vld[i]),
            .in_ctl   (ctl[i]),
            .in_rem   (rem[i]),
            .in_nq    (nq[i]),
            .in_dsr   (dsr[i]),
            .out_valid(vld[i+1]),
            .out_ctl  (ctl[i+1]),
            .out_rem  (rem[i+1]),
            .out_nq   (nq[i+1]),
            .out_dsr  (dsr[i+1])
        );
    end

    div128_fin #(
        .WIDTH(OPERAND_WIDTH)
    ) u_fin (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (vld[OPERAND_WIDTH]),
        .in_ctl   (ctl[OPERAND_WIDTH]),
        .in_rem   (rem[OPERAND_WIDTH]),
        .in_quo   (nq[OPERAND_WIDTH]),
        .out_valid(m_tvalid),
        .out_data (m_tdata),
        .out_dbz  (m_tuser)
    );

endmodule

// ===== hdl/div128_checker.sv =====
// Port-level checker for the divider core, bound to the top level.
// Depends on div128_pkg and divider_128_signed_unsigned_core_defines.svh.
`include "divider_128_signed_unsigned_core_defines.svh"

module div128_checker
    import div128_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tuser
);

    `DIV128_ASSERT_RST(a_idle_after_reset, $past(!aresetn) |-> !m_tvalid, "result beat right after reset")
    `DIV128_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `DIV128_ASSERT(a_ready_follows_out, s_tready == (!m_tvalid || m_tready), "input ready out of step with output stall")
    `DIV128_ASSERT(a_dbz_zero, m_tvalid && m_tuser |-> m_tdata == '0, "zero divisor beat with nonzero results")

endmodule

bind divider_128_signed_unsigned_core div128_checker u_div128_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking bench for divider_128_signed_unsigned_core: unsigned and signed 128-bit
// divide with quotient, remainder and divide-by-zero flag, with and without random stalls on both sides.
// Depends on div128_pkg and the core RTL only.
module tb_top
    import div128_pkg::*;
();

    localparam int OPW = OPERAND_WIDTH_DEF;
    localparam logic [FULL_W-1:0] WIDTH_MASK =
        (OPW >= FULL_W) ? {FULL_W{1'b1}} : ((128'd1 << OPW) - 128'd1);
    localparam logic [FULL_W-1:0] MIN_VAL = 128'd1 << (OPW - 1);
    localparam logic [FULL_W-1:0] MAX_VAL = MIN_VAL - 128'd1;
    localparam logic [FULL_W-1:0] NEG_ONE = WIDTH_MASK;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 200;

    typedef struct {
        logic [FULL_W-1:0] quo;
        logic [FULL_W-1:0] rem;
        logic              dbz;
    } div_result_t;

    class div_scoreboard;
        div_result_t due_results[$];
        int          mismatches;

        function div_result_t compute_divmod(logic op, logic [FULL_W-1:0] n,
                                             logic [FULL_W-1:0] d);
            div_result_t res;
            logic        n_neg;
            logic        d_neg;
            n = n & WIDTH_MASK;
            d = d & WIDTH_MASK;
            n_neg = 1'b0;
            d_neg = 1'b0;
            if (d == '0) begin
                res.quo = '0;
                res.rem = '0;
                res.dbz = 1'b1;
                return res;
            end
            if (op == OPC_SIGNED) begin
                n_neg = n[OPW-1];
                d_neg = d[OPW-1];
                if (n_neg) n = (-n) & WIDTH_MASK;
                if (d_neg) d = (-d) & WIDTH_MASK;
            end
            res.quo = n / d;
            res.rem = n % d;
            if (op == OPC_SIGNED) begin
                if (n_neg != d_neg) res.quo = -res.quo;
                if (n_neg) res.rem = -res.rem;
            end
            res.quo = res.quo & WIDTH_MASK;
            res.rem = res.rem & WIDTH_MASK;
            res.dbz = 1'b0;
            return res;
        endfunction

        function void note_operands(logic op, logic [DATA_W-1:0] data);
            due_results.push_back(compute_divmod(op, {data[63:0], data[127:64]},
                                                 {data[191:128], data[255:192]}));
        endfunction

        function void flag(string what, logic [FULL_W-1:0] exp_v, logic [FULL_W-1:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic dbz);
            div_result_t exp_r;
            if (due_results.size() == 0) begin
                flag("unexpected beat", '0, data[FULL_W-1:0]);
                return;
            end
            exp_r = due_results.pop_front();
            if (data[63:0] !== exp_r.quo[127:64])
                flag("quotient_hi", exp_r.quo[127:64], data[63:0]);
            if (data[127:64] !== exp_r.quo[63:0])
                flag("quotient_lo", exp_r.quo[63:0], data[127:64]);
            if (data[191:128] !== exp_r.rem[127:64])
                flag("remainder_hi", exp_r.rem[127:64], data[191:128]);
            if (data[255:192] !== exp_r.rem[63:0])
                flag("remainder_lo", exp_r.rem[63:0], data[255:192]);
            if (dbz !== exp_r.dbz)
                flag("divide_by_zero", FULL_W'(exp_r.dbz), FULL_W'(dbz));
        endfunction

        function void close_out();
            while (due_results.size() != 0) begin
                void'(due_results.pop_front());
                flag("missing beat", '0, '0);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    // dividend_hi, dividend_lo, divisor_hi, divisor_lo (64 bits each)
    logic [DATA_W-1:0] s_tdata;
    // opcode
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    // quotient_hi, quotient_lo, remainder_hi, remainder_lo (64 bits each)
    logic [DATA_W-1:0] m_tdata;
    // divide_by_zero
    logic              m_tuser;

    int            tx_idle_pct;
    int            rx_idle_pct;
    int unsigned   cycle_count = 0;
    div_scoreboard sb;

    divider_128_signed_unsigned_core #(.OPERAND_WIDTH(OPW)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    function automatic logic [FULL_W-1:0] rand_wide();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [FULL_W-1:0] rand_operand();
        logic [FULL_W-1:0] v;
        int                len;
        v = rand_wide();
        case ($urandom_range(9))
            0, 1, 2: ;
            3, 4, 5, 6: begin
                len = $urandom_range(1, FULL_W);
                if (len < FULL_W) v = v & ((128'd1 << len) - 128'd1);
            end
            7: v = FULL_W'($urandom_range(15));
            8: begin
                len = $urandom_range(1, FULL_W - 1);
                v = -(v & ((128'd1 << len) - 128'd1));
            end
            default: begin
                case ($urandom_range(5))
                    0: v = '0;
                    1: v = 128'd1;
                    2: v = NEG_ONE;
                    3: v = MIN_VAL;
                    4: v = MAX_VAL;
                    default: v = MIN_VAL + 128'd1;
                endcase
            end
        endcase
        return v & WIDTH_MASK;
    endfunction

    task automatic send_div(logic op, logic [FULL_W-1:0] n, logic [FULL_W-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {d[63:0], d[127:64], n[63:0], n[127:64]};
        do @(posedge aclk); while (!s_tready);
        sb.note_operands(s_tuser, s_tdata);
    endtask

    task automatic send_directed();
        send_div(OPC_UNSIGNED, 128'd12345, '0);
        send_div(OPC_SIGNED, NEG_ONE, '0);
        send_div(OPC_UNSIGNED, '0, '0);
        send_div(OPC_SIGNED, MIN_VAL, NEG_ONE);
        send_div(OPC_SIGNED, MIN_VAL, 128'd1);
        send_div(OPC_SIGNED, NEG_ONE, MIN_VAL);
        send_div(OPC_SIGNED, MIN_VAL, MIN_VAL);
        send_div(OPC_UNSIGNED, NEG_ONE, 128'd1);
        send_div(OPC_UNSIGNED, NEG_ONE, NEG_ONE);
        send_div(OPC_UNSIGNED, NEG_ONE, MIN_VAL);
        send_div(OPC_UNSIGNED, MIN_VAL + 128'd5, MIN_VAL + 128'd3);
        send_div(OPC_UNSIGNED, '0, 128'd7);
        send_div(OPC_UNSIGNED, 128'd7, NEG_ONE);
        send_div(OPC_SIGNED, 128'd7, 128'd2);
        send_div(OPC_SIGNED, -128'd7, 128'd2);
        send_div(OPC_SIGNED, 128'd7, -128'd2);
        send_div(OPC_SIGNED, -128'd7, -128'd2);
        send_div(OPC_SIGNED, MAX_VAL, NEG_ONE);
        send_div(OPC_SIGNED, MAX_VAL, MAX_VAL);
        send_div(OPC_UNSIGNED, {64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, {64'd1, 64'd0});
        send_div(OPC_UNSIGNED, {64'd3, 64'hFFFF_FFFF_FFFF_FFFF}, 128'd10);
        send_div(OPC_SIGNED, 128'd1, NEG_ONE);
    endtask

    initial begin
        sb          = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OPC_UNSIGNED;
        tx_idle_pct = 21;
        rx_idle_pct = 58;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 21; rx_idle_pct = 58; end
                1: begin tx_idle_pct = 58; rx_idle_pct = 21; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (phase == 0) send_directed();
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_div($urandom_range(1) ? OPC_SIGNED : OPC_UNSIGNED,
                         rand_operand(), rand_operand());
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (OPW + 10) @(posedge aclk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/div128_pkg.sv
hdl/div128_prep.sv
hdl/div128_cell.sv
hdl/div128_fin.sv
hdl/divider_128_signed_unsigned_core.sv
hdl/div128_checker.sv
dv/tb_top.sv
